FILE: src/sqe_pkg.sv
`default_nettype none

package sqe_pkg;

    // Number of cells in the row, and the width of a count that can reach it.
    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int VAL_W = 32;
    localparam int OP_W  = 3;
    localparam int ST_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_SWAP = 3'd2,
        OP_PEEK = 3'd3,
        OP_DUMP = 3'd4
    } sqe_op_t;

    typedef enum logic [ST_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_PEEK_EMPTY = 3'd1,
        STAT_POP_EMPTY  = 3'd2,
        STAT_SWAP_SHORT = 3'd3,
        STAT_FULL       = 3'd4
    } sqe_status_t;

    // What the whole row does on each clock.
    typedef enum logic [2:0] {
        ROW_HOLD,
        ROW_PUSH_TOP,
        ROW_APPEND,
        ROW_POP,
        ROW_SWAP,
        ROW_ROTATE
    } sqe_row_cmd_t;

    // What a single cell does in one cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_PREV,
        CELL_TAKE_NEXT,
        CELL_ROTATE,
        CELL_APPEND
    } sqe_cell_cmd_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] val;
    } sqe_link_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } sqe_state_t;

endpackage

`default_nettype wire

FILE: src/stack_queue_engine_top.sv
// Channel   Direction  Signals                              Contents
// s_        in         s_tvalid s_tready s_tuser s_tdata    operation, value to push
// m_        out        m_tvalid m_tready m_tuser m_tdata    status, has_value, value_out
//                      m_tlast                              last
// cfg_      in         cfg_valid cfg_ready cfg_wdata        queue_mode
//
// Push, pop, swap, peek, undefined operations and a dump of an empty store each give one result.
// A dump of N stored entries takes its request and then gives N results from the dump
// state, one rotation of the cell row per result, each loaded only when the output
// register is free; no request is taken until the last result has been loaded.
// Reset is synchronous on aresetn low; it empties the store and clears queue_mode.
// A stalled result holds in the output register; a new request is taken only when that
// register is empty or being emptied in the same cycle.
`default_nettype none

module stack_queue_engine_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Request channel.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sqe_pkg::OP_W-1:0]         s_tuser,   // [2:0] operation
    input  wire logic signed [sqe_pkg::VAL_W-1:0] s_tdata,   // [31:0] value
    // Result channel.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sqe_pkg::ST_W:0]                m_tuser,   // [2:0] status, [3] has_value
    output logic signed [sqe_pkg::VAL_W-1:0]      m_tdata,   // [31:0] value_out
    output logic                                  m_tlast,
    // Configuration write channel.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_wdata  // queue_mode
);
    import sqe_pkg::*;

    // Control state.
    sqe_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        remain_reg, remain_next;
    logic                    queue_mode_reg;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    sqe_status_t             m_status_reg, m_status_next;
    logic                    m_has_reg, m_has_next;
    logic signed [VAL_W-1:0] m_val_reg, m_val_next;
    logic                    m_last_reg, m_last_next;

    sqe_row_cmd_t            row_cmd;
    sqe_link_t               top_link;
    sqe_op_t                 op;
    logic                    out_free;
    logic                    s_accept;
    logic                    is_empty, is_full, is_short;

    assign op       = sqe_op_t'(s_tuser);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_short = (count_reg < CNT_W'(2));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        row_cmd       = ROW_HOLD;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_has_next    = m_has_reg;
        m_val_next    = m_val_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Default result: ok, no value, last.
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_has_next    = 1'b0;
                    m_val_next    = '0;
                    m_last_next   = 1'b1;
                    case (op)
                        OP_PUSH: begin
                            if (is_full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                row_cmd    = queue_mode_reg ? ROW_APPEND : ROW_PUSH_TOP;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                m_status_next = STAT_POP_EMPTY;
                            end else begin
                                row_cmd    = ROW_POP;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_SWAP: begin
                            if (is_short) begin
                                m_status_next = STAT_SWAP_SHORT;
                            end else begin
                                row_cmd = ROW_SWAP;
                            end
                        end
                        OP_PEEK: begin
                            if (is_empty) begin
                                m_status_next = STAT_PEEK_EMPTY;
                            end else begin
                                m_has_next = 1'b1;
                                m_val_next = top_link.val;
                            end
                        end
                        OP_DUMP: begin
                            // A non-empty dump streams from the dump state instead.
                            if (!is_empty) begin
                                m_valid_next = 1'b0;
                                remain_next  = count_reg;
                                state_next   = ST_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                // Each result takes the top cell and rotates the occupied cells up by one,
                // so after a full pass the row is back in its original order.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_has_next    = 1'b1;
                    m_val_next    = top_link.val;
                    m_last_next   = (remain_reg == CNT_W'(1));
                    row_cmd       = ROW_ROTATE;
                    remain_next   = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            remain_reg     <= '0;
            queue_mode_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                queue_mode_reg <= cfg_wdata;
            end
        end
        m_status_reg <= m_status_next;
        m_has_reg    <= m_has_next;
        m_val_reg    <= m_val_next;
        m_last_reg   <= m_last_next;
    end

    sqe_cell_row u_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .row_cmd  (row_cmd),
        .push_val (s_tdata),
        .top_link (top_link)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = {m_has_reg, m_status_reg};
    assign m_tdata   = m_val_reg;
    assign m_tlast   = m_last_reg;

    // The count never leaves its range.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A dump never changes the entry count.
    a_dump_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |=> $stable(count_reg))
        else $error("entry count changed during dump");

    // The dump state always has at least one entry left to send.
    a_dump_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> (remain_reg != '0 && remain_reg <= count_reg))
        else $error("dump remainder out of range");

    // A result without a stored entry carries a zero value.
    a_no_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_has_reg) |-> (m_val_reg == '0))
        else $error("value_out not zero without has_value");

    // The top cell is occupied exactly when the count is non-zero.
    a_top_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        top_link.vld == !is_empty)
        else $error("top cell occupancy disagrees with count");

endmodule

`default_nettype wire

FILE: src/sqe_cell.sv
`default_nettype none

module sqe_cell (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire sqe_pkg::sqe_cell_cmd_t          cmd,
    input  wire logic signed [sqe_pkg::VAL_W-1:0] push_val,
    input  wire logic signed [sqe_pkg::VAL_W-1:0] top_val,
    input  wire sqe_pkg::sqe_link_t              prev_link,
    input  wire sqe_pkg::sqe_link_t              next_link,
    output sqe_pkg::sqe_link_t                   link
);
    import sqe_pkg::*;

    logic                    vld_reg, vld_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    always_comb begin
        vld_next = vld_reg;
        val_next = val_reg;
        case (cmd)
            CELL_TAKE_PREV: begin
                vld_next = prev_link.vld;
                val_next = prev_link.val;
            end
            CELL_TAKE_NEXT: begin
                vld_next = next_link.vld;
                val_next = next_link.val;
            end
            CELL_ROTATE: begin
                // The last occupied cell wraps the old top value around.
                if (next_link.vld) begin
                    val_next = next_link.val;
                end else if (vld_reg) begin
                    val_next = top_val;
                end
            end
            CELL_APPEND: begin
                // Only the first free cell below the occupied ones takes the value.
                if (prev_link.vld && !vld_reg) begin
                    vld_next = 1'b1;
                    val_next = push_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign link.vld = vld_reg;
    assign link.val = val_reg;

endmodule

`default_nettype wire

FILE: src/sqe_cell_row.sv
`default_nettype none

module sqe_cell_row (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire sqe_pkg::sqe_row_cmd_t            row_cmd,
    input  wire logic signed [sqe_pkg::VAL_W-1:0] push_val,
    output sqe_pkg::sqe_link_t                    top_link
);
    import sqe_pkg::*;

    sqe_link_t links [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sqe_link_t     prev_link;
        sqe_link_t     next_link;
        sqe_cell_cmd_t cmd;

        if (i == 0) begin : g_first
            // Above the top sits the value being pushed, always present.
            assign prev_link.vld = 1'b1;
            assign prev_link.val = push_val;
        end else begin : g_mid
            assign prev_link = links[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_link = '0;
        end else begin : g_inner
            assign next_link = links[i+1];
        end

        always_comb begin
            case (row_cmd)
                ROW_PUSH_TOP: cmd = CELL_TAKE_PREV;
                ROW_APPEND:   cmd = CELL_APPEND;
                ROW_POP:      cmd = CELL_TAKE_NEXT;
                ROW_ROTATE:   cmd = CELL_ROTATE;
                ROW_SWAP: begin
                    if (i == 0) begin
                        cmd = CELL_TAKE_NEXT;
                    end else if (i == 1) begin
                        cmd = CELL_TAKE_PREV;
                    end else begin
                        cmd = CELL_HOLD;
                    end
                end
                default:      cmd = CELL_HOLD;
            endcase
        end

        sqe_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .push_val  (push_val),
            .top_val   (links[0].val),
            .prev_link (prev_link),
            .next_link (next_link),
            .link      (links[i])
        );
    end

    assign top_link = links[0];

endmodule

`default_nettype wire
